### rtl/core/rle8bd_pkg.sv
// Shared types and constants of the RLE8 bitmap decoder.
// Used by the parser, the result queue and the top level; depends on nothing.
`timescale 1ns / 1ps

package rle8bd_pkg;

  // Configuration register width and register indexes.
  localparam int unsigned CFG_W = 13;
  localparam logic [1:0] CFG_IDX_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_IDX_DOWNWARD = 2'd2;

  // Column may run up to the width plus one delta byte; the row may also dip below zero.
  localparam int unsigned COL_W = 14;
  localparam int unsigned ROW_W = 15;

  // Result queue.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  typedef enum logic [7:0] {
    PH_COUNT     = 8'b0000_0001,
    PH_VALUE     = 8'b0000_0010,
    PH_DX        = 8'b0000_0100,
    PH_DY        = 8'b0000_1000,
    PH_LIT       = 8'b0001_0000,
    PH_PAD       = 8'b0010_0000,
    PH_DONE_OK   = 8'b0100_0000,
    PH_DONE_FAIL = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FILL = 2'd0,
    KIND_LIT  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_FAIL = 2'd3
  } kind_e;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             downward;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  run_length;
    logic [7:0]  value;
    logic        final_result;
  } result_t;

  // Up to two results are produced by one request, the write always first.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

### rtl/core/rle8bd_parser.sv
// Stream parser of the RLE8 bitmap decoder: position and phase registers and
// the per-byte decode logic. Depends on rle8bd_pkg.
`timescale 1ns / 1ps

module rle8bd_parser #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_i,
  input  logic                eos_i,
  input  rle8bd_pkg::cfg_t    cfg_i,
  output rle8bd_pkg::push_t   push_o
);

  localparam logic [16:0] MaxDim = 17'(MAX_DIM);
  localparam int unsigned ColW   = rle8bd_pkg::COL_W;
  localparam int unsigned RowW   = rle8bd_pkg::ROW_W;

  rle8bd_pkg::phase_e phase_q, phase_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [7:0]         held_q, held_d;
  logic [7:0]         lit_q, lit_d;
  logic               pad_q, pad_d;
  logic               fresh_q, fresh_d;

  logic [rle8bd_pkg::CFG_W-1:0] eff_w, eff_h;
  logic signed [RowW-1:0]       eff_h_s, start_row, row_c, row_step, row_delta, row_new;
  logic [ColW-1:0]              col_c;
  logic [ColW:0]                col_plus_held, col_plus_b;
  logic [ColW:0]                eff_w_x;
  logic [7:0]                   lit_dec;
  logic                         write_vld, status_vld;
  rle8bd_pkg::kind_e            status_kind;
  rle8bd_pkg::result_t          write_res, status_res;

  function automatic logic row_inside(input logic signed [RowW-1:0] r,
                                      input logic signed [RowW-1:0] h);
    row_inside = (r >= 0) && (r < h);
  endfunction

  // Dimensions above the supported maximum behave as the maximum.
  assign eff_w = ({4'b0, cfg_i.width} > MaxDim) ? MaxDim[rle8bd_pkg::CFG_W-1:0] : cfg_i.width;
  assign eff_h = ({4'b0, cfg_i.height} > MaxDim) ? MaxDim[rle8bd_pkg::CFG_W-1:0] : cfg_i.height;

  assign eff_h_s   = $signed({2'b00, eff_h});
  assign eff_w_x   = {2'b00, eff_w};
  assign start_row = cfg_i.downward ? '0 : eff_h_s - RowW'(1);

  // The first byte of an image starts from column zero and the start row.
  assign col_c = fresh_q ? '0 : col_q;
  assign row_c = fresh_q ? start_row : $signed(row_q);

  assign col_plus_held = {1'b0, col_c} + (ColW+1)'(held_q);
  assign col_plus_b    = {1'b0, col_c} + (ColW+1)'(data_i);
  assign row_step      = cfg_i.downward ? RowW'(1) : -RowW'(1);
  assign row_delta     = cfg_i.downward ? $signed({7'b0, data_i}) : -$signed({7'b0, data_i});
  assign lit_dec       = lit_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    col_d       = col_q;
    row_d       = row_q;
    held_d      = held_q;
    lit_d       = lit_q;
    pad_d       = pad_q;
    fresh_d     = fresh_q;
    row_new     = row_c;
    write_vld   = 1'b0;
    status_vld  = 1'b0;
    status_kind = rle8bd_pkg::KIND_FAIL;
    write_res   = '0;
    status_res  = '0;
    push_o      = '0;

    if (accept_i) begin
      if (phase_q == rle8bd_pkg::PH_DONE_OK || phase_q == rle8bd_pkg::PH_DONE_FAIL) begin
        // Bytes after an early status are absorbed until the last-marked one.
        if (eos_i) begin
          status_vld  = 1'b1;
          status_kind = (phase_q == rle8bd_pkg::PH_DONE_OK) ? rle8bd_pkg::KIND_OK
                                                            : rle8bd_pkg::KIND_FAIL;
        end
      end else begin
        fresh_d = 1'b0;
        col_d   = col_c;
        row_d   = row_c;
        case (phase_q)
          rle8bd_pkg::PH_COUNT: begin
            if (!row_inside(row_c, eff_h_s)) begin
              status_vld  = 1'b1;
              status_kind = rle8bd_pkg::KIND_OK;
            end else begin
              held_d  = data_i;
              phase_d = rle8bd_pkg::PH_VALUE;
            end
          end
          rle8bd_pkg::PH_VALUE: begin
            if (held_q != 8'd0) begin
              if (col_plus_held > eff_w_x) begin
                status_vld = 1'b1;
              end else begin
                write_vld            = 1'b1;
                write_res.kind       = rle8bd_pkg::KIND_FILL;
                write_res.row        = row_c[11:0];
                write_res.column     = col_c[11:0];
                write_res.run_length = held_q;
                write_res.value      = data_i;
                col_d                = col_plus_held[ColW-1:0];
                phase_d              = rle8bd_pkg::PH_COUNT;
              end
            end else if (data_i == 8'd0) begin
              row_new = row_c + row_step;
              col_d   = '0;
              row_d   = row_new;
              if (!row_inside(row_new, eff_h_s)) begin
                status_vld  = 1'b1;
                status_kind = rle8bd_pkg::KIND_OK;
              end else begin
                phase_d = rle8bd_pkg::PH_COUNT;
              end
            end else if (data_i == 8'd1) begin
              status_vld  = 1'b1;
              status_kind = rle8bd_pkg::KIND_OK;
            end else if (data_i == 8'd2) begin
              phase_d = rle8bd_pkg::PH_DX;
            end else begin
              if (col_plus_b > eff_w_x) begin
                status_vld = 1'b1;
              end else begin
                lit_d   = data_i;
                pad_d   = data_i[0];
                phase_d = rle8bd_pkg::PH_LIT;
              end
            end
          end
          rle8bd_pkg::PH_DX: begin
            col_d   = col_plus_b[ColW-1:0];
            phase_d = rle8bd_pkg::PH_DY;
          end
          rle8bd_pkg::PH_DY: begin
            row_new = row_c + row_delta;
            row_d   = row_new;
            if ({1'b0, col_c} > eff_w_x || !row_inside(row_new, eff_h_s)) begin
              status_vld = 1'b1;
            end else begin
              phase_d = rle8bd_pkg::PH_COUNT;
            end
          end
          rle8bd_pkg::PH_LIT: begin
            write_vld            = 1'b1;
            write_res.kind       = rle8bd_pkg::KIND_LIT;
            write_res.row        = row_c[11:0];
            write_res.column     = col_c[11:0];
            write_res.run_length = 8'd1;
            write_res.value      = data_i;
            col_d                = col_c + ColW'(1);
            lit_d                = lit_dec;
            if (lit_dec == 8'd0) begin
              phase_d = pad_q ? rle8bd_pkg::PH_PAD : rle8bd_pkg::PH_COUNT;
            end
          end
          rle8bd_pkg::PH_PAD: begin
            pad_d   = 1'b0;
            phase_d = rle8bd_pkg::PH_COUNT;
          end
          default: begin
            phase_d = rle8bd_pkg::PH_COUNT;
          end
        endcase

        // A last-marked byte that leaves the image open is a truncated stream.
        if (!status_vld && eos_i) begin
          status_vld  = 1'b1;
          status_kind = rle8bd_pkg::KIND_FAIL;
        end
        if (status_vld && !eos_i) begin
          phase_d = (status_kind == rle8bd_pkg::KIND_OK) ? rle8bd_pkg::PH_DONE_OK
                                                         : rle8bd_pkg::PH_DONE_FAIL;
        end
      end

      // The closing status rearms the parser for the next image.
      if (status_vld && eos_i) begin
        phase_d = rle8bd_pkg::PH_COUNT;
        col_d   = '0;
        held_d  = '0;
        lit_d   = '0;
        pad_d   = 1'b0;
        fresh_d = 1'b1;
      end

      status_res.kind         = status_kind;
      status_res.final_result = eos_i;

      if (write_vld && status_vld) begin
        push_o.count = 2'd2;
        push_o.res0  = write_res;
        push_o.res1  = status_res;
      end else if (write_vld) begin
        push_o.count = 2'd1;
        push_o.res0  = write_res;
      end else if (status_vld) begin
        push_o.count = 2'd1;
        push_o.res0  = status_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rle8bd_pkg::PH_COUNT;
      col_q   <= '0;
      row_q   <= '0;
      held_q  <= '0;
      lit_q   <= '0;
      pad_q   <= 1'b0;
      fresh_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      held_q  <= held_d;
      lit_q   <= lit_d;
      pad_q   <= pad_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

### rtl/core/rle8bd_res_fifo.sv
// Four-entry result queue of the RLE8 bitmap decoder: takes up to two results
// per cycle from the parser and hands out one per cycle while pop_i is high. Depends on rle8bd_pkg.
`timescale 1ns / 1ps

module rle8bd_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rle8bd_pkg::push_t   push_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                valid_o,
  output rle8bd_pkg::result_t head_o
);

  localparam int unsigned PtrW = rle8bd_pkg::RES_PTR_W;
  localparam int unsigned CntW = rle8bd_pkg::RES_CNT_W;

  rle8bd_pkg::result_t mem_q [rle8bd_pkg::RES_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // A request is taken only while two entries are free, so both results always fit.
  assign room_o  = (cnt_q <= CntW'(rle8bd_pkg::RES_DEPTH - 2));
  assign do_pop  = pop_i && valid_o;

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + PtrW'(do_pop);
  assign cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(do_pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/core/rle8_bitmap_decoder_unit.sv
// RLE8 bitmap decoder, top level: configuration registers, parser and result queue.
// Depends on rle8bd_pkg, rle8bd_parser and rle8bd_res_fifo.
//
// The decoder takes one compressed byte per clock cycle while its result queue has room and
// turns it into fill-run writes, literal pixel writes and a closing status for each image.
// A byte is decoded in the cycle it is accepted, and its results appear on the master side
// from the next cycle on. The results pass through a four-entry queue that the master side
// drains at one result per cycle while it is ready; the slave side is ready while that queue
// has at least two free entries, so the sustained rate is one byte per cycle as long as
// results are taken. Configuration must be written only between images, while the block is
// idle; the block itself leaves this to the user.
`timescale 1ns / 1ps

module rle8_bitmap_decoder_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_wdata_i,
  // Compressed byte stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_stream
  // Decoded results.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [11:0] pixel_row, [23:12] pixel_column,
                                        // [31:24] run_length, [39:32] pixel_value
  output logic [1:0]  m_axis_tuser_o,   // [1:0] result_kind
  output logic        m_axis_tlast_o    // final_result
);

  rle8bd_pkg::cfg_t    cfg_q, cfg_d;
  rle8bd_pkg::push_t   push;
  rle8bd_pkg::result_t head;
  logic                room, in_fire;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        rle8bd_pkg::CFG_IDX_WIDTH:    cfg_d.width    = cfg_wdata_i;
        rle8bd_pkg::CFG_IDX_HEIGHT:   cfg_d.height   = cfg_wdata_i;
        rle8bd_pkg::CFG_IDX_DOWNWARD: cfg_d.downward = cfg_wdata_i[0];
        default:                      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= 13'd1;
      cfg_q.height   <= 13'd1;
      cfg_q.downward <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign s_axis_tready_o = room;
  assign in_fire         = s_axis_tvalid_i && room;

  rle8bd_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .data_i   (s_axis_tdata_i),
    .eos_i    (s_axis_tlast_i),
    .cfg_i    (cfg_q),
    .push_o   (push)
  );

  rle8bd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready_i),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {head.value, head.run_length, head.column, head.row};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.final_result;

endmodule

### verif/tb_top.sv
// Self-checking testbench of the RLE8 bitmap decoder: a clocked driver and monitor around the
// block, with a behavioural decoder that predicts every write and every closing status.
// Depends on rle8bd_pkg and rle8_bitmap_decoder_unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int DIM_LIMIT   = 4096;
  localparam int RANDOM_BYTES = 1950;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rle8bd_pkg::CFG_IDX_WIDTH;
  logic [12:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  rle8_bitmap_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),     // [7:0] data_byte
    .s_axis_tlast_i  (s_last),     // end_of_stream
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),     // [11:0] row, [23:12] column, [31:24] length, [39:32] value
    .m_axis_tuser_o  (m_user),     // [1:0] result_kind
    .m_axis_tlast_o  (m_last)      // final_result
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  stream_byte_t        pending_bytes[$];
  stream_byte_t        image_bytes[$];
  rle8bd_pkg::result_t pixel_results_q[$];
  int                  error_count = 0;
  bit                  byte_taken = 1'b0;
  bit                  hold_sender = 1'b0;

  // Shadow of the configuration registers and of the decoder state.
  int                 cfg_width, cfg_height;
  bit                 cfg_downward;
  rle8bd_pkg::phase_e dec_phase;
  int                 dec_col, dec_row, dec_count, dec_lit_left;
  bit                 dec_pad, dec_done, dec_fresh;

  function automatic int eff_dim(input int v);
    return (v > DIM_LIMIT) ? DIM_LIMIT : v;
  endfunction

  function automatic int start_row();
    return cfg_downward ? 0 : eff_dim(cfg_height) - 1;
  endfunction

  function automatic rle8bd_pkg::result_t make_result(input rle8bd_pkg::kind_e k,
                                                      input int row, input int col,
                                                      input int len, input int val,
                                                      input bit fin);
    rle8bd_pkg::result_t r;
    r.kind         = k;
    r.row          = 12'(row);
    r.column       = 12'(col);
    r.run_length   = 8'(len);
    r.value        = 8'(val);
    r.final_result = fin;
    return r;
  endfunction

  task automatic restart_image();
    dec_phase    = rle8bd_pkg::PH_COUNT;
    dec_col      = 0;
    dec_row      = start_row();
    dec_count    = 0;
    dec_lit_left = 0;
    dec_pad      = 1'b0;
    dec_done     = 1'b0;
    dec_fresh    = 1'b1;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    int                ew, eh, db;
    bit                has_status;
    rle8bd_pkg::kind_e status;
    ew         = eff_dim(cfg_width);
    eh         = eff_dim(cfg_height);
    db         = int'(b);
    has_status = 1'b0;
    status     = rle8bd_pkg::KIND_OK;
    if (dec_done) begin
      // Bytes after an early status are swallowed until the last-marked one.
      if (eos) begin
        pixel_results_q.push_back(make_result(
            (dec_phase == rle8bd_pkg::PH_DONE_OK) ? rle8bd_pkg::KIND_OK
                                                  : rle8bd_pkg::KIND_FAIL,
            0, 0, 0, 0, 1'b1));
        restart_image();
      end
    end else begin
      if (dec_fresh) begin
        dec_col   = 0;
        dec_row   = start_row();
        dec_fresh = 1'b0;
      end
      case (dec_phase)
        rle8bd_pkg::PH_COUNT: begin
          if (dec_row < 0 || dec_row >= eh) begin
            has_status = 1'b1;
            status     = rle8bd_pkg::KIND_OK;
          end else begin
            dec_count = db;
            dec_phase = rle8bd_pkg::PH_VALUE;
          end
        end
        rle8bd_pkg::PH_VALUE: begin
          if (dec_count != 0) begin
            if (dec_col + dec_count > ew) begin
              has_status = 1'b1;
              status     = rle8bd_pkg::KIND_FAIL;
            end else begin
              pixel_results_q.push_back(make_result(rle8bd_pkg::KIND_FILL, dec_row, dec_col,
                                                    dec_count, db, 1'b0));
              dec_col   = dec_col + dec_count;
              dec_phase = rle8bd_pkg::PH_COUNT;
            end
          end else if (db == 0) begin
            dec_col = 0;
            dec_row = dec_row + (cfg_downward ? 1 : -1);
            if (dec_row < 0 || dec_row >= eh) begin
              has_status = 1'b1;
              status     = rle8bd_pkg::KIND_OK;
            end else begin
              dec_phase = rle8bd_pkg::PH_COUNT;
            end
          end else if (db == 1) begin
            has_status = 1'b1;
            status     = rle8bd_pkg::KIND_OK;
          end else if (db == 2) begin
            dec_phase = rle8bd_pkg::PH_DX;
          end else if (dec_col + db > ew) begin
            has_status = 1'b1;
            status     = rle8bd_pkg::KIND_FAIL;
          end else begin
            dec_lit_left = db;
            dec_pad      = db[0];
            dec_phase    = rle8bd_pkg::PH_LIT;
          end
        end
        rle8bd_pkg::PH_DX: begin
          dec_col   = dec_col + db;
          dec_phase = rle8bd_pkg::PH_DY;
        end
        rle8bd_pkg::PH_DY: begin
          dec_row = dec_row + (cfg_downward ? db : -db);
          if (dec_col > ew || dec_row < 0 || dec_row >= eh) begin
            has_status = 1'b1;
            status     = rle8bd_pkg::KIND_FAIL;
          end else begin
            dec_phase = rle8bd_pkg::PH_COUNT;
          end
        end
        rle8bd_pkg::PH_LIT: begin
          pixel_results_q.push_back(make_result(rle8bd_pkg::KIND_LIT, dec_row, dec_col, 1, db,
                                                1'b0));
          dec_col      = dec_col + 1;
          dec_lit_left = (dec_lit_left - 1) & 255;
          if (dec_lit_left == 0) begin
            dec_phase = dec_pad ? rle8bd_pkg::PH_PAD : rle8bd_pkg::PH_COUNT;
          end
        end
        default: begin
          dec_pad   = 1'b0;
          dec_phase = rle8bd_pkg::PH_COUNT;
        end
      endcase
      // A last-marked byte that leaves the image open is a truncated stream.
      if (!has_status && eos) begin
        has_status = 1'b1;
        status     = rle8bd_pkg::KIND_FAIL;
      end
      if (has_status) begin
        pixel_results_q.push_back(make_result(status, 0, 0, 0, 0, eos));
        if (eos) begin
          restart_image();
        end else begin
          dec_done  = 1'b1;
          dec_phase = (status == rle8bd_pkg::KIND_OK) ? rle8bd_pkg::PH_DONE_OK
                                                      : rle8bd_pkg::PH_DONE_FAIL;
        end
      end
    end
  endtask

  // Monitor: both handshakes are sampled at the rising edge.
  always @(posedge clk_i) begin
    rle8bd_pkg::result_t got, want;
    bit                  bad;
    byte_taken <= rst_ni && s_valid && s_ready;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        decode_byte(s_data, s_last);
      end
      if (m_valid && m_ready) begin
        got = make_result(rle8bd_pkg::kind_e'(m_user), int'(m_data[11:0]),
                          int'(m_data[23:12]), int'(m_data[31:24]), int'(m_data[39:32]),
                          m_last);
        if (pixel_results_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result kind=%0d row=%0d col=%0d len=%0d val=%0d last=%0d",
                   $realtime, got.kind, got.row, got.column, got.run_length, got.value,
                   got.final_result);
        end else begin
          want = pixel_results_q.pop_front();
          bad  = (got.kind !== want.kind) || (got.row !== want.row) ||
                 (got.column !== want.column) || (got.run_length !== want.run_length) ||
                 (got.value !== want.value) || (got.final_result !== want.final_result);
          if (bad) begin
            error_count++;
            $display("%0t: expected kind=%0d row=%0d col=%0d len=%0d val=%0d last=%0d",
                     $realtime, want.kind, want.row, want.column, want.run_length,
                     want.value, want.final_result);
            $display("%0t:   actual kind=%0d row=%0d col=%0d len=%0d val=%0d last=%0d",
                     $realtime, got.kind, got.row, got.column, got.run_length, got.value,
                     got.final_result);
          end
        end
      end
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Driver of the compressed byte stream.
  int send_gap = 0;
  int send_burst = 0;
  always @(negedge clk_i) begin
    stream_byte_t item;
    if (!s_valid || byte_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_valid <= 1'b0;
      end else if (pending_bytes.size() > 0 && !hold_sender) begin
        item    = pending_bytes.pop_front();
        s_valid <= 1'b1;
        s_data  <= item.data;
        s_last  <= item.last;
        if (send_burst > 0) begin
          send_burst--;
        end else if ($urandom_range(0, 49) == 0) begin
          send_burst = $urandom_range(40, 200);
        end else if ($urandom_range(0, 9) < 3) begin
          send_gap = idle_length();
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Back-pressure on the result side.
  int recv_stall = 0;
  int recv_burst = 0;
  always @(negedge clk_i) begin
    if (recv_stall > 0) begin
      recv_stall--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (recv_burst > 0) begin
        recv_burst--;
      end else if ($urandom_range(0, 49) == 0) begin
        recv_burst = $urandom_range(40, 200);
      end else if ($urandom_range(0, 4) == 0) begin
        recv_stall = idle_length();
      end
    end
  end

  task automatic write_reg(input logic [1:0] index, input int value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= 13'(value);
    case (index)
      rle8bd_pkg::CFG_IDX_WIDTH:  cfg_width = value & 13'h1FFF;
      rle8bd_pkg::CFG_IDX_HEIGHT: cfg_height = value & 13'h1FFF;
      default:                    cfg_downward = value[0];
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int w, input int h, input bit td);
    write_reg(rle8bd_pkg::CFG_IDX_WIDTH, w);
    write_reg(rle8bd_pkg::CFG_IDX_HEIGHT, h);
    write_reg(rle8bd_pkg::CFG_IDX_DOWNWARD, int'(td));
  endtask

  // Waits until the block has delivered everything.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_valid || pixel_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
  endtask

  task automatic add_byte(input int b, input bit last);
    stream_byte_t item;
    item.data = 8'(b);
    item.last = last;
    image_bytes.push_back(item);
  endtask

  // Moves the assembled image to the driver, optionally marking its final byte.
  task automatic flush_image(input bit mark_last);
    stream_byte_t tail;
    if (mark_last) begin
      tail      = image_bytes.pop_back();
      tail.last = 1'b1;
      image_bytes.push_back(tail);
    end
    while (image_bytes.size() > 0) pending_bytes.push_back(image_bytes.pop_front());
  endtask

  // Builds one mostly well-formed image for an effective frame of ew by eh pixels.
  task automatic gen_image(input int ew, input int eh);
    int gcol, rows_left, n_ops, k, op, rem, cnt, lim, dx, dy, ending;
    gcol      = 0;
    rows_left = eh;
    n_ops     = $urandom_range(1, 10);
    for (k = 0; k < n_ops; k++) begin
      rem = ew - gcol;
      op  = $urandom_range(0, 99);
      if (op < 40 && rem > 0) begin
        cnt = $urandom_range(1, (rem > 255) ? 255 : rem);
        add_byte(cnt, 1'b0);
        add_byte($urandom_range(0, 255), 1'b0);
        gcol += cnt;
      end else if (op < 55) begin
        add_byte(0, 1'b0);
        add_byte(0, 1'b0);
        gcol = 0;
        rows_left--;
      end else if (op < 65) begin
        dx = $urandom_range(0, (rem < 0) ? 0 : ((rem > 20) ? 20 : rem));
        dy = $urandom_range(0, (rows_left > 4) ? 3 : ((rows_left > 1) ? rows_left - 1 : 0));
        add_byte(0, 1'b0);
        add_byte(2, 1'b0);
        add_byte(dx, 1'b0);
        add_byte(dy, 1'b0);
        gcol += dx;
        rows_left -= dy;
      end else if (op < 85 && rem >= 3) begin
        lim = ($urandom_range(0, 9) == 0) ? 255 : 24;
        cnt = $urandom_range(3, (rem > lim) ? lim : rem);
        add_byte(0, 1'b0);
        add_byte(cnt, 1'b0);
        repeat (cnt) add_byte($urandom_range(0, 255), 1'b0);
        if (cnt % 2 == 1) add_byte($urandom_range(0, 255), 1'b0);
        gcol += cnt;
      end else begin
        add_byte($urandom_range(0, 255), 1'b0);
        add_byte($urandom_range(0, 255), 1'b0);
      end
    end
    ending = $urandom_range(0, 9);
    if (ending <= 5) begin
      add_byte(0, 1'b0);
      add_byte(1, 1'b1);
      flush_image(1'b0);
    end else if (ending == 6) begin
      add_byte(0, 1'b0);
      add_byte(1, 1'b0);
      repeat ($urandom_range(1, 3)) add_byte($urandom_range(0, 255), 1'b0);
      flush_image(1'b1);
    end else if (ending == 7) begin
      if (image_bytes.size() == 0) add_byte($urandom_range(0, 255), 1'b0);
      flush_image(1'b1);
    end else if (ending == 8) begin
      repeat ($urandom_range(1, 4)) add_byte($urandom_range(0, 255), 1'b0);
      flush_image(1'b1);
    end else begin
      // Step the row off the edge of the frame before the end escape.
      repeat ((rows_left > 4) ? 4 : ((rows_left < 0) ? 1 : rows_left + 1)) begin
        add_byte(0, 1'b0);
        add_byte(0, 1'b0);
      end
      add_byte(0, 1'b0);
      add_byte(1, 1'b1);
      flush_image(1'b0);
    end
  endtask

  initial begin
    int bytes_made, before_phase, phase_no, n_images, sel, w, h, half;
    cfg_width    = 1;
    cfg_height   = 1;
    cfg_downward = 1'b0;
    restart_image();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: fill, end of line, odd literal with pad, delta, end of bitmap.
    configure(8, 2, 1'b0);
    add_byte(3, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(0, 1'b0); add_byte(0, 1'b0);
    add_byte(0, 1'b0); add_byte(3, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h7F, 1'b0); add_byte(8'hAA, 1'b0);
    add_byte(0, 1'b0); add_byte(2, 1'b0); add_byte(1, 1'b0); add_byte(0, 1'b0);
    add_byte(0, 1'b0); add_byte(1, 1'b1);
    // Fill overrun reported early, then swallowed up to the last byte.
    add_byte(9, 1'b0); add_byte(8'h55, 1'b0); add_byte(8'h12, 1'b1);
    // Delta beyond the right edge on the last byte.
    add_byte(0, 1'b0); add_byte(2, 1'b0); add_byte(9, 1'b0); add_byte(0, 1'b1);
    // Stream cut short on a count byte.
    add_byte(5, 1'b1);
    flush_image(1'b0);
    wait_idle();

    // Empty frame: the first byte already closes the image.
    configure(8, 0, 1'b1);
    add_byte(7, 1'b0); add_byte(1, 1'b1);
    flush_image(1'b0);
    wait_idle();

    bytes_made = 0;
    phase_no   = 0;
    while (bytes_made < RANDOM_BYTES) begin
      sel = $urandom_range(0, 11);
      case (sel)
        0:       begin w = 4096; h = $urandom_range(1, 4); end
        1:       begin w = 8191; h = $urandom_range(1, 3); end
        2:       begin w = $urandom_range(1, 16); h = 4096; end
        3:       begin w = $urandom_range(1, 16); h = 8191; end
        4:       begin w = 1; h = 1; end
        5:       begin
          w = $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8190);
          h = $urandom_range(0, 3);
        end
        default: begin w = $urandom_range(1, 48); h = $urandom_range(1, 6); end
      endcase
      configure(w, h, 1'($urandom_range(0, 1)));
      before_phase = pending_bytes.size();
      n_images     = $urandom_range(3, 10);
      repeat (n_images) gen_image(eff_dim(cfg_width), eff_dim(cfg_height));
      bytes_made += pending_bytes.size() - before_phase;
      if (phase_no % 3 == 1) begin
        // Halfway through, hold the sender back until the results have caught up.
        half = pending_bytes.size() / 2;
        while (pending_bytes.size() > half) @(posedge clk_i);
        hold_sender = 1'b1;
        while (s_valid || pixel_results_q.size() != 0) @(posedge clk_i);
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      wait_idle();
      phase_no++;
    end

    if (error_count == 0) begin
      $display("rle8_bitmap_decoder_unit: match");
    end else begin
      $display("rle8_bitmap_decoder_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("rle8_bitmap_decoder_unit: mismatch");
    $finish;
  end

endmodule
